@@ rtl/core/kcts_pkg.sv @@
package kcts_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int KEY_W = 48;
  localparam int CHAN_W = 32;
  localparam int PREF_W = 3;
  localparam int MET_W = 32;
  localparam int ENT_W = KEY_W + CHAN_W + PREF_W + MET_W;

  localparam logic [3:0] OP_SET = 4'd0;
  localparam logic [3:0] OP_UNSET = 4'd1;
  localparam logic [3:0] OP_CLEAR = 4'd2;
  localparam logic [3:0] OP_SETPREF = 4'd3;
  localparam logic [3:0] OP_ADDMET = 4'd4;
  localparam logic [3:0] OP_SETMET = 4'd5;
  localparam logic [3:0] OP_LOOKUP = 4'd6;
  localparam logic [3:0] OP_READ = 4'd7;
  localparam logic [3:0] OP_SORT = 4'd8;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOKEY = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  localparam logic [2:0] PREF_NONE = 3'd0;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CHAN_W-1:0] chan;
    logic [PREF_W-1:0] pref;
    logic [MET_W-1:0] metric;
  } entry_t;

  typedef struct packed {
    logic [3:0] op;
    logic [KEY_W-1:0] mac_key;
    logic [31:0] channel_word;
    logic [2:0] pref_code;
    logic [31:0] metric_value;
    logic [3:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_found;
    logic [KEY_W-1:0] mac_out;
    logic [31:0] channel_out;
    logic [2:0] pref_out;
    logic [31:0] metric_out;
    logic [4:0] entry_count;
  } out_item_t;

  // memory port bundle from sequencer to table
  typedef struct packed {
    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t wr_data;
  } mem_req_t;
endpackage

@@ rtl/core/kcts_if.sv @@
interface kcts_in_if;
  import kcts_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kcts_out_if;
  import kcts_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/kcts_mem.sv @@
module kcts_mem
  import kcts_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);
  entry_t mem [ENTRIES];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end
endmodule

@@ rtl/core/kcts_seq.sv @@
module kcts_seq
  import kcts_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  kcts_in_if.sink       in_ch,
  kcts_out_if.source    out_ch,
  output mem_req_t      req,
  input  entry_t        rd_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;  // scan for key
  localparam logic [3:0] S_ACT = 4'd2;   // act on found entry
  localparam logic [3:0] S_SHIFT = 4'd3; // unset compaction
  localparam logic [3:0] S_CLR = 4'd4;
  localparam logic [3:0] S_SORTJ = 4'd5; // load element j
  localparam logic [3:0] S_SORTI = 4'd6; // compare with i-1
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_WAIT = 4'd8;  // read latency bubble
  localparam logic [3:0] S_SORTP = 4'd9; // place element j at the head

  logic [3:0] state_r, state_nxt;
  logic [3:0] ret_r, ret_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  entry_t hold_r, hold_nxt;

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res_r;

  // fill result fields from one entry
  function automatic out_item_t rep(out_item_t r, logic [CNT_W-1:0] pos, entry_t e);
    out_item_t o;
    o = r;
    o.slot_found = pos[IDX_W-1:0];
    o.mac_out = e.key;
    o.channel_out = e.chan;
    o.pref_out = e.pref;
    o.metric_out = e.metric;
    return o;
  endfunction

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    item_nxt = item_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    fill_nxt = fill_r;
    i_nxt = i_r;
    j_nxt = j_r;
    hold_nxt = hold_r;
    req = '0;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          item_nxt = in_ch.data;
          res_nxt = '0;
          i_nxt = '0;
          case (in_ch.data.op)
            OP_SET, OP_UNSET, OP_SETPREF, OP_ADDMET, OP_SETMET, OP_LOOKUP: begin
              if (fill_r == '0) state_nxt = S_ACT;
              else begin
                req.rd_en = 1'b1;
                req.rd_addr = '0;
                ret_nxt = S_SRCH;
                state_nxt = S_WAIT;
              end
            end
            OP_READ: begin
              if ({1'b0, in_ch.data.slot_index} >= fill_r) begin
                res_nxt.status = ST_RANGE;
                state_nxt = S_DONE;
              end else begin
                req.rd_en = 1'b1;
                req.rd_addr = in_ch.data.slot_index;
                i_nxt = {1'b0, in_ch.data.slot_index};
                ret_nxt = S_ACT;
                state_nxt = S_WAIT;
              end
            end
            OP_CLEAR: begin
              if (fill_r == '0) state_nxt = S_DONE;
              else begin
                req.rd_en = 1'b1;
                ret_nxt = S_CLR;
                state_nxt = S_WAIT;
              end
            end
            OP_SORT: begin
              j_nxt = CNT_W'(1);
              state_nxt = S_SORTJ;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_WAIT: state_nxt = ret_r;
      S_SRCH: begin
        if (rd_data.key == item_r.mac_key) state_nxt = S_ACT;
        else if (i_r + 1'b1 >= fill_r) begin
          i_nxt = fill_r;
          state_nxt = S_ACT;
        end else begin
          i_nxt = i_r + 1'b1;
          req.rd_en = 1'b1;
          req.rd_addr = IDX_W'(i_r + 1'b1);
          ret_nxt = S_SRCH;
          state_nxt = S_WAIT;
        end
      end
      S_ACT: begin
        // i_r == fill_r means key absent (read index never hits this)
        state_nxt = S_DONE;
        if (item_r.op == OP_READ) res_nxt = rep(res_r, i_r, rd_data);
        else if (i_r == fill_r) begin
          if (item_r.op == OP_SET) begin
            if (fill_r == CNT_W'(ENTRIES)) res_nxt.status = ST_FULL;
            else begin
              req.wr_en = 1'b1;
              req.wr_addr = IDX_W'(fill_r);
              req.wr_data = '{item_r.mac_key, item_r.channel_word, PREF_NONE, '0};
              res_nxt = rep(res_r, fill_r, req.wr_data);
              fill_nxt = fill_r + 1'b1;
            end
          end else res_nxt.status = ST_NOKEY;
        end else begin
          req.wr_addr = IDX_W'(i_r);
          req.wr_data = rd_data;
          case (item_r.op)
            OP_SET: begin
              req.wr_en = 1'b1;
              req.wr_data = '{item_r.mac_key, item_r.channel_word, PREF_NONE, '0};
            end
            OP_SETPREF: begin
              if (rd_data.pref != PREF_NONE) res_nxt.status = ST_REFUSED;
              else begin
                req.wr_en = 1'b1;
                req.wr_data.pref = item_r.pref_code;
              end
            end
            OP_ADDMET: begin
              req.wr_en = 1'b1;
              req.wr_data.metric = rd_data.metric + item_r.metric_value;
            end
            OP_SETMET: begin
              req.wr_en = 1'b1;
              req.wr_data.metric = item_r.metric_value;
            end
            default: ;
          endcase
          res_nxt = rep(res_nxt, i_r, req.wr_data);
          if (item_r.op == OP_UNSET) begin
            fill_nxt = fill_r - 1'b1;
            if (i_r + 1'b1 < fill_r) begin
              req.rd_en = 1'b1;
              req.rd_addr = IDX_W'(i_r + 1'b1);
              ret_nxt = S_SHIFT;
              state_nxt = S_WAIT;
            end
          end
        end
      end
      S_SHIFT: begin
        // move entry i+1 down to i
        req.wr_en = 1'b1;
        req.wr_addr = IDX_W'(i_r);
        req.wr_data = rd_data;
        i_nxt = i_r + 1'b1;
        if (i_r + CNT_W'(2) < fill_r + 1'b1) begin
          req.rd_en = 1'b1;
          req.rd_addr = IDX_W'(i_r + CNT_W'(2));
          ret_nxt = S_SHIFT;
          state_nxt = S_WAIT;
        end else state_nxt = S_DONE;
      end
      S_CLR: begin
        req.wr_en = 1'b1;
        req.wr_addr = IDX_W'(i_r);
        req.wr_data = rd_data;
        req.wr_data.pref = PREF_NONE;
        req.wr_data.metric = '0;
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 < fill_r) begin
          req.rd_en = 1'b1;
          req.rd_addr = IDX_W'(i_r + 1'b1);
          ret_nxt = S_CLR;
          state_nxt = S_WAIT;
        end else state_nxt = S_DONE;
      end
      S_SORTJ: begin
        if (j_r >= fill_r) state_nxt = S_DONE;
        else begin
          req.rd_en = 1'b1;
          req.rd_addr = IDX_W'(j_r);
          i_nxt = j_r;
          ret_nxt = S_SORTI;
          state_nxt = S_WAIT;
        end
      end
      S_SORTI: begin
        // first visit captures element j, later ones hold entry i-1
        if (ret_r == S_SORTI) begin
          hold_nxt = rd_data;
          req.rd_en = 1'b1;
          req.rd_addr = IDX_W'(i_r - 1'b1);
          ret_nxt = S_SORTJ;
          state_nxt = S_WAIT;
        end else if (rd_data.metric < hold_r.metric) begin
          // shift entry i-1 up one place
          req.wr_en = 1'b1;
          req.wr_addr = IDX_W'(i_r);
          req.wr_data = rd_data;
          i_nxt = i_r - 1'b1;
          if (i_r == CNT_W'(1)) state_nxt = S_SORTP;
          else begin
            req.rd_en = 1'b1;
            req.rd_addr = IDX_W'(i_r - CNT_W'(2));
            ret_nxt = S_SORTJ;
            state_nxt = S_WAIT;
          end
        end else begin
          req.wr_en = 1'b1;
          req.wr_addr = IDX_W'(i_r);
          req.wr_data = hold_r;
          j_nxt = j_r + 1'b1;
          state_nxt = S_SORTJ;
        end
      end
      S_SORTP: begin
        req.wr_en = 1'b1;
        req.wr_addr = IDX_W'(i_r);
        req.wr_data = hold_r;
        j_nxt = j_r + 1'b1;
        state_nxt = S_SORTJ;
      end
      S_DONE: begin
        res_nxt.entry_count = fill_r;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // the sort loop returns through S_WAIT into S_SORTI with ret marking entry i-1
    if (state_r == S_WAIT && ret_r == S_SORTJ) state_nxt = S_SORTI;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_r <= '0;
      ret_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r <= fill_nxt;
      ret_r <= ret_nxt;
    end
    item_r <= item_nxt;
    res_r <= res_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    hold_r <= hold_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(ENTRIES)) else $error("fill count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE && !out_valid_r) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid_r) else $error("result lost");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != $past(fill_r) |-> $past(state_r) == S_ACT) else $error("bad fill change");
endmodule

@@ rtl/core/keyed_candidate_table_sort_top.sv @@
// keyed candidate table with a stable descending metric sort
// in_ channel: one transaction per operation (set, unset, clear, set
// preference, add/set metric, lookup, read index, sort); out_ channel:
// exactly one result transaction per operation, in order.
// one item is in flight at a time; in_ready is low until its result
// has been taken from the output register.
// the sequencer walks the entries held one at a time through the single
// table memory, whose read port is registered.
// reset (synchronous, rst_n low) empties the table; entry contents are
// not cleared, only the fill count.
// when the receiver stalls the result holds in the output register and
// no new item is accepted.
module keyed_candidate_table_sort_top
  import kcts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  kcts_in_if.sink     in_ch,
  kcts_out_if.source  out_ch
);
  mem_req_t req;
  entry_t rd_data;

  kcts_mem u_mem (.clk(clk), .req(req), .rd_data(rd_data));

  kcts_seq u_seq (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .req(req), .rd_data(rd_data)
  );
endmodule

@@ bench/keyed_candidate_table_sort_top_test.sv @@
module keyed_candidate_table_sort_top_test;
  import kcts_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kcts_in_if in_ch ();
  kcts_out_if out_ch ();

  keyed_candidate_table_sort_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // table shadow used to predict results
  logic [KEY_W-1:0]  shadow_key [ENTRIES];
  logic [CHAN_W-1:0] shadow_chan [ENTRIES];
  logic [PREF_W-1:0] shadow_pref [ENTRIES];
  logic [MET_W-1:0]  shadow_metric [ENTRIES];
  int                shadow_fill;

  out_item_t expected_results [$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        quiet_cycles;
  logic      timed_out;

  // directed stimulus row: item plus optional typed-in result
  typedef struct {
    in_item_t  item;
    logic      has_fixed;
    out_item_t fixed;
  } directed_row_t;

  function automatic int find_entry(logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_fill; i++)
      if (shadow_key[i] == key) return i;
    return -1;
  endfunction

  function automatic out_item_t entry_report(int i);
    out_item_t r;
    r = '0;
    r.slot_found = i[3:0];
    r.mac_out = shadow_key[i];
    r.channel_out = shadow_chan[i];
    r.pref_out = shadow_pref[i];
    r.metric_out = shadow_metric[i];
    return r;
  endfunction

  // apply one operation to the shadow table and give its result
  function automatic out_item_t apply_table_op(in_item_t it);
    out_item_t r;
    int i;
    int j;
    logic [KEY_W-1:0]  k;
    logic [CHAN_W-1:0] c;
    logic [PREF_W-1:0] p;
    logic [MET_W-1:0]  m;
    r = '0;
    case (it.op)
      OP_SET: begin
        i = find_entry(it.mac_key);
        if (i < 0 && shadow_fill >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          if (i < 0) begin
            i = shadow_fill;
            shadow_fill++;
          end
          shadow_key[i] = it.mac_key;
          shadow_chan[i] = it.channel_word;
          shadow_pref[i] = PREF_NONE;
          shadow_metric[i] = '0;
          r = entry_report(i);
        end
      end
      OP_UNSET: begin
        i = find_entry(it.mac_key);
        if (i < 0) begin
          r.status = ST_NOKEY;
        end else begin
          r = entry_report(i);
          for (j = i; j + 1 < shadow_fill; j++) begin
            shadow_key[j] = shadow_key[j+1];
            shadow_chan[j] = shadow_chan[j+1];
            shadow_pref[j] = shadow_pref[j+1];
            shadow_metric[j] = shadow_metric[j+1];
          end
          shadow_fill--;
        end
      end
      OP_CLEAR: begin
        for (j = 0; j < shadow_fill; j++) begin
          shadow_pref[j] = PREF_NONE;
          shadow_metric[j] = '0;
        end
      end
      OP_SETPREF, OP_ADDMET, OP_SETMET, OP_LOOKUP: begin
        i = find_entry(it.mac_key);
        if (i < 0) begin
          r.status = ST_NOKEY;
        end else begin
          if (it.op == OP_SETPREF) begin
            if (shadow_pref[i] != PREF_NONE) r.status = ST_REFUSED;
            else shadow_pref[i] = it.pref_code;
          end else if (it.op == OP_ADDMET) begin
            shadow_metric[i] = shadow_metric[i] + it.metric_value;
          end else if (it.op == OP_SETMET) begin
            shadow_metric[i] = it.metric_value;
          end
          r.slot_found = i[3:0];
          r.mac_out = shadow_key[i];
          r.channel_out = shadow_chan[i];
          r.pref_out = shadow_pref[i];
          r.metric_out = shadow_metric[i];
        end
      end
      OP_READ: begin
        if (int'(it.slot_index) >= shadow_fill) r.status = ST_RANGE;
        else r = entry_report(int'(it.slot_index));
      end
      OP_SORT: begin
        // stable insertion sort, largest metric first
        for (j = 1; j < shadow_fill; j++) begin
          k = shadow_key[j];
          c = shadow_chan[j];
          p = shadow_pref[j];
          m = shadow_metric[j];
          i = j;
          while (i > 0 && shadow_metric[i-1] < m) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_chan[i] = shadow_chan[i-1];
            shadow_pref[i] = shadow_pref[i-1];
            shadow_metric[i] = shadow_metric[i-1];
            i--;
          end
          shadow_key[i] = k;
          shadow_chan[i] = c;
          shadow_pref[i] = p;
          shadow_metric[i] = m;
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_fill[4:0];
    return r;
  endfunction

  // drive one transaction and wait for it to be taken; valid stays high
  // afterwards so items can follow back to back
  task automatic send_item(in_item_t it);
    while (($urandom % 100) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_predicted(in_item_t it);
    expected_results.push_back(apply_table_op(it));
    send_item(it);
  endtask

  // random field values with the extremes weighted in
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item(logic [KEY_W-1:0] key_pool [8], bit noisy);
    in_item_t it;
    it.op = noisy ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
    if ($urandom_range(0, 9) == 0) it.mac_key = {16'($urandom), 32'($urandom)};
    else it.mac_key = key_pool[$urandom_range(0, 7)];
    it.channel_word = rand_word();
    it.pref_code = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
    it.metric_value = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 40)) : rand_word();
    it.slot_index = 4'($urandom);
    return it;
  endfunction

  // receiver and result check
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (($urandom % 100) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transaction %h", out_ch.data);
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_ch.data.status ||
              want.slot_found !== out_ch.data.slot_found ||
              want.mac_out !== out_ch.data.mac_out ||
              want.channel_out !== out_ch.data.channel_out ||
              want.pref_out !== out_ch.data.pref_out ||
              want.metric_out !== out_ch.data.metric_out ||
              want.entry_count !== out_ch.data.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %h actual %h", want, out_ch.data);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) timed_out <= 1'b1;
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    directed_row_t rows [$];
    directed_row_t row;
    in_item_t it;
    out_item_t r;
    logic [KEY_W-1:0] key_pool [8];
    int wait_cycles;

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    shadow_fill = 0;
    send_idle_pct = 9;
    recv_idle_pct = 62;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty-table results typed in, rest predicted
    it = '0;
    it.op = OP_READ; it.slot_index = 4'd0;
    row.item = it; row.has_fixed = 1'b1; row.fixed = '0; row.fixed.status = ST_RANGE;
    rows.push_back(row);
    it.op = OP_LOOKUP; it.mac_key = '1;
    row.item = it; row.fixed.status = ST_NOKEY;
    rows.push_back(row);
    it.op = OP_UNSET;
    row.item = it; rows.push_back(row);
    it.op = OP_SORT;
    row.item = it; row.fixed.status = ST_OK; rows.push_back(row);
    it.op = OP_CLEAR;
    row.item = it; rows.push_back(row);
    it.op = 4'd15;
    row.item = it; rows.push_back(row);
    row.has_fixed = 1'b0;
    // fill the table to the brim and overflow
    for (int n = 0; n < 17; n++) begin
      it = '0;
      it.op = OP_SET;
      it.mac_key = (n == 0) ? '0 : (n == 1) ? '1 : KEY_W'(n * 48'h0101_0101_0101);
      it.channel_word = (n == 1) ? '1 : 32'(n);
      row.item = it;
      rows.push_back(row);
    end
    it = '0; it.op = OP_SETPREF; it.mac_key = '1; it.pref_code = 3'd7;
    row.item = it; rows.push_back(row);
    rows.push_back(row);
    it.op = OP_ADDMET; it.metric_value = '1;
    row.item = it; rows.push_back(row);
    it.metric_value = 32'd2;
    row.item = it; rows.push_back(row);
    it.op = OP_SORT;
    row.item = it; rows.push_back(row);

    foreach (rows[n]) begin
      r = apply_table_op(rows[n].item);
      expected_results.push_back(rows[n].has_fixed ? rows[n].fixed : r);
      send_item(rows[n].item);
    end
    in_ch.valid <= 1'b0;

    // hold off until everything is back
    while (expected_results.size() != 0) @(posedge clk);

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 9 : 0;
      for (int s = 0; s < 8; s++) key_pool[s] = {16'($urandom), 32'($urandom)};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int n = 0; n < 570; n++) begin
        it = rand_item(key_pool, ($urandom_range(0, 19) == 0));
        // bias toward sets early so the table fills
        if (shadow_fill < 4 && $urandom_range(0, 1) == 0) it.op = OP_SET;
        send_predicted(it);
      end
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < STALL_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (400) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/kcts_pkg.sv
rtl/core/kcts_if.sv
rtl/core/kcts_mem.sv
rtl/core/kcts_seq.sv
rtl/core/keyed_candidate_table_sort_top.sv
bench/keyed_candidate_table_sort_top_test.sv
